FILE: hw/rtl/dspt_pkg.sv
// shared constants and types for the divisor sum and perfect number test
package dspt_pkg;

   localparam int NUM_WIDTH = 32;
   localparam int IN_W      = 32;
   localparam int SUM_W     = 35;
   localparam int GEO_W     = NUM_WIDTH + 1;
   localparam int UNIT_W    = (SUM_W > GEO_W) ? SUM_W : GEO_W;
   localparam int D_W       = NUM_WIDTH / 2 + 2;
   localparam int DSQ_W     = NUM_WIDTH + 2;
   localparam int DIV_STEPS = NUM_WIDTH;
   localparam int MUL_STEPS = GEO_W;
   localparam int CNT_W     = $clog2(MUL_STEPS);

   typedef enum logic {
      UOP_DIV = 1'b0,
      UOP_MUL = 1'b1
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

FILE: hw/rtl/dspt_iter_unit.sv
// shared one-bit-per-cycle divide and multiply unit
module dspt_iter_unit import dspt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  unit_cmd_type       cmd,
   input  logic [UNIT_W-1:0]  opa,
   input  logic [GEO_W-1:0]   opb,
   output unit_sts_type       sts,
   output logic [UNIT_W-1:0]  acc,
   output logic [NUM_WIDTH-1:0] quo
);

   logic              busy_ff, busy_in;
   unit_op_type       op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [UNIT_W-1:0] acc_ff, acc_in;
   logic [UNIT_W-1:0] a_ff, a_in;
   logic [GEO_W-1:0]  b_ff, b_in;

   logic [CNT_W-1:0]  last;
   logic [UNIT_W-1:0] shifted;
   logic [UNIT_W-1:0] diff;
   logic              fits;

   assign last    = (op_ff == UOP_DIV) ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
   // restoring divide: remainder takes the next dividend bit
   assign shifted = {acc_ff[UNIT_W-2:0], a_ff[NUM_WIDTH-1]};
   assign diff    = shifted - UNIT_W'(b_ff);
   assign fits    = shifted >= UNIT_W'(b_ff);

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = opa;
         b_in    = opb;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == last) begin
            busy_in = 1'b0;
         end
         if (op_ff == UOP_DIV) begin
            acc_in = fits ? diff : shifted;
            a_in   = {a_ff[UNIT_W-2:0], fits};
         end else begin
            // shift-add multiply, kept modulo 2^UNIT_W
            acc_in = acc_ff + (b_ff[0] ? a_ff : '0);
            a_in   = {a_ff[UNIT_W-2:0], 1'b0};
            b_in   = {1'b0, b_ff[GEO_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = busy_ff && (cnt_ff == last);
   assign acc      = acc_ff;
   assign quo      = a_ff[NUM_WIDTH-1:0];

endmodule

FILE: hw/rtl/divisor_sum_perfect_test.sv
// Sum of divisors and perfect number test by trial division. One number is
// taken at a time; req_ready is high only while the block is idle. Every trial
// divide and every multiply goes through one shared unit that retires one bit
// per cycle; factors of two are stripped by shifts instead. Each odd trial
// divisor up to the square root of what is left costs one divide, and a
// leftover prime above it is folded in with one multiply. Each power of a
// prime factor found adds a multiply and a divide, and each prime factor one
// more multiply. Input zero gives a sum of zero and is never perfect. A
// finished result sits in an output register, and the next number may be
// transferred while it waits.
module divisor_sum_perfect_test import dspt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [IN_W-1:0]  req_number,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [SUM_W-1:0] rsp_divisor_sum,
   output logic             rsp_is_perfect
);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_TWO    = 12'b0000_0000_0010,
      ST_CHECK  = 12'b0000_0000_0100,
      ST_DIV    = 12'b0000_0000_1000,
      ST_EVAL   = 12'b0000_0001_0000,
      ST_PMUL   = 12'b0000_0010_0000,
      ST_PTAKE  = 12'b0000_0100_0000,
      ST_TMUL   = 12'b0000_1000_0000,
      ST_TTAKE  = 12'b0001_0000_0000,
      ST_LMUL   = 12'b0010_0000_0000,
      ST_LTAKE  = 12'b0100_0000_0000,
      ST_FINISH = 12'b1000_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [NUM_WIDTH-1:0]   n_ff, n_in;
   logic [NUM_WIDTH-1:0]   rest_ff, rest_in;
   logic [NUM_WIDTH-1:0]   power_ff, power_in;
   logic [GEO_W-1:0]       geo_ff, geo_in;
   logic [SUM_W-1:0]       total_ff, total_in;
   logic [D_W-1:0]         d_ff, d_in;
   logic [DSQ_W-1:0]       dsq_ff, dsq_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]       rsp_sum_ff, rsp_sum_in;
   logic                   rsp_perfect_ff, rsp_perfect_in;

   unit_cmd_type           cmd;
   unit_sts_type           sts;
   logic [UNIT_W-1:0]      unit_a;
   logic [GEO_W-1:0]       unit_b;
   logic [UNIT_W-1:0]      unit_acc;
   logic [NUM_WIDTH-1:0]   unit_quo;

   logic                   req_xfer;
   logic                   out_free;
   logic [NUM_WIDTH-1:0]   n_new;
   logic [NUM_WIDTH-1:0]   power_dbl;
   logic [NUM_WIDTH-1:0]   power_prod;
   logic [D_W-1:0]         d_step;
   logic [DSQ_W-1:0]       dsq_step;

   dspt_iter_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .opa   (unit_a),
      .opb   (unit_b),
      .sts   (sts),
      .acc   (unit_acc),
      .quo   (unit_quo)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign n_new      = NUM_WIDTH'(req_number);
   assign power_dbl  = {power_ff[NUM_WIDTH-2:0], 1'b0};
   assign power_prod = unit_acc[NUM_WIDTH-1:0];
   assign d_step     = d_ff + D_W'(2);
   // (d + 2)^2 = d^2 + 4d + 4
   assign dsq_step   = dsq_ff + (DSQ_W'(d_ff) << 2) + DSQ_W'(4);

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      rest_in     = rest_ff;
      power_in    = power_ff;
      geo_in      = geo_ff;
      total_in    = total_ff;
      d_in        = d_ff;
      dsq_in      = dsq_ff;
      cmd.start   = 1'b0;
      cmd.op      = UOP_DIV;
      unit_a      = UNIT_W'(rest_ff);
      unit_b      = GEO_W'(d_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               n_in     = n_new;
               rest_in  = n_new;
               power_in = NUM_WIDTH'(1);
               geo_in   = GEO_W'(1);
               if (n_new == '0) begin
                  total_in = '0;
                  state_in = ST_FINISH;
               end else begin
                  total_in = SUM_W'(1);
                  state_in = ST_TWO;
               end
            end
         end
         ST_TWO: begin
            if (!rest_ff[0]) begin
               rest_in  = rest_ff >> 1;
               power_in = power_dbl;
               geo_in   = geo_ff + GEO_W'(power_dbl);
            end else begin
               total_in = SUM_W'(geo_ff);
               d_in     = D_W'(3);
               dsq_in   = DSQ_W'(9);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (dsq_ff <= DSQ_W'(rest_ff)) begin
               power_in  = NUM_WIDTH'(1);
               geo_in    = GEO_W'(1);
               cmd.start = 1'b1;
               cmd.op    = UOP_DIV;
               state_in  = ST_DIV;
            end else if (rest_ff > NUM_WIDTH'(1)) begin
               // leftover prime above the square root
               cmd.start = 1'b1;
               cmd.op    = UOP_MUL;
               unit_a    = UNIT_W'(total_ff);
               unit_b    = GEO_W'(rest_ff) + GEO_W'(1);
               state_in  = ST_LMUL;
            end else begin
               state_in  = ST_FINISH;
            end
         end
         ST_DIV: begin
            if (sts.done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (unit_acc == '0) begin
               rest_in   = unit_quo;
               cmd.start = 1'b1;
               cmd.op    = UOP_MUL;
               unit_a    = UNIT_W'(power_ff);
               unit_b    = GEO_W'(d_ff);
               state_in  = ST_PMUL;
            end else if (geo_ff != GEO_W'(1)) begin
               cmd.start = 1'b1;
               cmd.op    = UOP_MUL;
               unit_a    = UNIT_W'(total_ff);
               unit_b    = geo_ff;
               state_in  = ST_TMUL;
            end else begin
               d_in     = d_step;
               dsq_in   = dsq_step;
               state_in = ST_CHECK;
            end
         end
         ST_PMUL: begin
            if (sts.done) begin
               state_in = ST_PTAKE;
            end
         end
         ST_PTAKE: begin
            power_in  = power_prod;
            geo_in    = geo_ff + GEO_W'(power_prod);
            cmd.start = 1'b1;
            cmd.op    = UOP_DIV;
            state_in  = ST_DIV;
         end
         ST_TMUL: begin
            if (sts.done) begin
               state_in = ST_TTAKE;
            end
         end
         ST_TTAKE: begin
            total_in = unit_acc[SUM_W-1:0];
            d_in     = d_step;
            dsq_in   = dsq_step;
            state_in = ST_CHECK;
         end
         ST_LMUL: begin
            if (sts.done) begin
               state_in = ST_LTAKE;
            end
         end
         ST_LTAKE: begin
            total_in = unit_acc[SUM_W-1:0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_sum_in     = rsp_sum_ff;
      rsp_perfect_in = rsp_perfect_ff;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_sum_in     = total_ff;
         rsp_perfect_in = (n_ff != '0) && (total_ff == SUM_W'({n_ff, 1'b0}));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      rest_ff        <= rest_in;
      power_ff       <= power_in;
      geo_ff         <= geo_in;
      total_ff       <= total_in;
      d_ff           <= d_in;
      dsq_ff         <= dsq_in;
      rsp_sum_ff     <= rsp_sum_in;
      rsp_perfect_ff <= rsp_perfect_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_divisor_sum = rsp_sum_ff;
   assign rsp_is_perfect  = rsp_perfect_ff;

endmodule
